>>> hdl/otm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// otm_pkg: shared types and constants of the ordered timer manager
// Command codes, default sizes and the item passed from front to back.
// ---------------------------------------------------------------------------
package otm_pkg;
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int CMD_W = 3;
  localparam int SLOT_W = 4;
  localparam int WIN_W = 48;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 48'd3600000;

  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COLLECT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

  // item passed through the command queue (times are full 48 bit ports)
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [47:0]       now;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       period;
    logic              rep;
    logic              fnow;
  } otm_item_t;
endpackage

>>> hdl/otm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// otm_front: command intake and queue
// Takes items on start and holds them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module otm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  otm_pkg::otm_item_t in_item,
  output logic              busy,
  output logic              q_valid,
  output otm_pkg::otm_item_t q_item,
  input  logic              q_pop
);
  import otm_pkg::*;

  otm_item_t  mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> hdl/otm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// otm_back: timer table and command sequencer
// Executes one queued item at a time; scans the slots one per cycle for
// order searches and emits expired slots in (deadline, index) order.
// ---------------------------------------------------------------------------
module otm_back #(
  parameter int NUM_SLOTS = otm_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = otm_pkg::TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [otm_pkg::WIN_W-1:0] cfg_data,
  input  logic                    q_valid,
  input  otm_pkg::otm_item_t      q_item,
  output logic                    q_pop,
  output logic                    strobe,
  output logic                    ok,
  output logic [otm_pkg::SLOT_W-1:0] slot_out,
  output logic                    expired,
  output logic [47:0]             next_delay,
  output logic                    front_notice,
  output logic                    any_active,
  output logic                    last
);
  import otm_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] NS = CW'(NUM_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_NOTICE, S_QUERY, S_DUE, S_PICK, S_UPD, S_DONE
  } state_t;

  state_t state;
  logic [TIME_BITS-1:0] per_mem [NUM_SLOTS];
  logic [TIME_BITS-1:0] dl_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act, rep, due;
  logic [TIME_BITS-1:0] prev_time;
  logic                 notice_pend;
  logic [WIN_W-1:0]     window;

  logic [TIME_BITS-1:0] now_t;
  logic [CW-1:0]        scan;
  logic [IW-1:0]        tgt, best;
  logic                 best_ok, roll, found;
  logic [TIME_BITS-1:0] best_dl;

  logic [IW-1:0]        si, fi;
  logic                 in_range, any_free;
  logic [NUM_SLOTS-1:0] act_after;
  logic [TIME_BITS-1:0] qnow, qper;
  logic                 strobe_next;

  assign qnow = TIME_BITS'(q_item.now);
  assign qper = TIME_BITS'(q_item.period);
  assign si = IW'(q_item.slot);
  assign in_range = ({{(32-SLOT_W){1'b0}}, q_item.slot} < NUM_SLOTS);
  assign q_pop = (state == S_IDLE) && q_valid;

  // first free slot
  always_comb begin
    fi = '0;
    any_free = 1'b0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!act[j]) begin
        fi = IW'(j);
        any_free = 1'b1;
      end
    end
  end

  // scan element and comparison against current best
  logic [IW-1:0]        sj;
  logic                 sj_before;
  assign sj = scan[IW-1:0];
  assign sj_before = !best_ok || (dl_mem[sj] < best_dl);

  // result strobe for the next cycle
  always_comb begin
    strobe_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.cmd)
            CMD_ADD:     strobe_next = !any_free;
            CMD_RESET:   strobe_next = !(in_range && act[si] &&
                                         !((qper == per_mem[si]) && !q_item.fnow));
            CMD_COLLECT: strobe_next = !(|act);
            CMD_QUERY:   strobe_next = 1'b0;
            default:     strobe_next = 1'b1;
          endcase
        end
      end
      S_NOTICE, S_QUERY: strobe_next = (scan == NS);
      S_PICK:  strobe_next = (scan == NS) && !best_ok;
      S_UPD:   strobe_next = 1'b1;
      default: strobe_next = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      act         <= '0;
      prev_time   <= '0;
      notice_pend <= 1'b0;
      window      <= WINDOW_RESET;
      strobe      <= 1'b0;
      any_active  <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cfg_we) window <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            now_t   <= qnow;
            expired <= 1'b0;
            next_delay <= '0;
            front_notice <= 1'b0;
            last    <= 1'b1;
            scan    <= '0;
            best_ok <= 1'b0;
            found   <= 1'b0;
            unique case (q_item.cmd)
              CMD_ADD: begin
                if (any_free) begin
                  per_mem[fi] <= qper;
                  dl_mem[fi]  <= qnow + qper;
                  rep[fi]     <= q_item.rep;
                  act[fi]     <= 1'b1;
                  tgt         <= fi;
                  ok          <= 1'b1;
                  slot_out    <= SLOT_W'(fi);
                  state       <= S_NOTICE;
                end else begin
                  ok <= 1'b0;
                  slot_out <= '0;
                  any_active <= |act;
                end
              end
              CMD_CANCEL: begin
                ok <= in_range && act[si];
                slot_out <= q_item.slot;
                if (in_range && act[si]) begin
                  act[si] <= 1'b0;
                  any_active <= |(act & ~(NUM_SLOTS'(1) << si));
                end else begin
                  any_active <= |act;
                end
              end
              CMD_REFRESH: begin
                ok <= in_range && act[si];
                slot_out <= q_item.slot;
                if (in_range && act[si]) dl_mem[si] <= qnow + per_mem[si];
                any_active <= |act;
              end
              CMD_RESET: begin
                slot_out <= q_item.slot;
                if (in_range && (qper == per_mem[si]) && !q_item.fnow) begin
                  ok <= 1'b1;
                  any_active <= |act;
                end else if (in_range && act[si]) begin
                  per_mem[si] <= qper;
                  dl_mem[si] <= (q_item.fnow ? qnow : dl_mem[si] - per_mem[si]) + qper;
                  tgt <= si;
                  ok <= 1'b1;
                  state <= S_NOTICE;
                end else begin
                  ok <= 1'b0;
                  any_active <= |act;
                end
              end
              CMD_COLLECT: begin
                if (|act) begin
                  roll <= (qnow < prev_time) &&
                          (WIN_W'(prev_time - qnow) > window ||
                           ((prev_time - qnow) >> WIN_W) != '0);
                  prev_time <= qnow;
                  state <= S_DUE;
                end else begin
                  ok <= 1'b1;
                  slot_out <= '0;
                  any_active <= 1'b0;
                end
              end
              CMD_QUERY: begin
                notice_pend <= 1'b0;
                ok <= 1'b1;
                slot_out <= '0;
                state <= S_QUERY;
              end
              default: begin
                ok <= 1'b0;
                slot_out <= '0;
                any_active <= |act;
              end
            endcase
          end
        end
        // front check: any other active slot ahead of tgt
        S_NOTICE: begin
          if (scan == NS) begin
            front_notice <= !found && !notice_pend;
            if (!found) notice_pend <= 1'b1;
            any_active <= |act;
            state <= S_IDLE;
          end else begin
            if (sj != tgt && act[sj] &&
                ((dl_mem[sj] < dl_mem[tgt]) ||
                 (dl_mem[sj] == dl_mem[tgt] && sj < tgt)))
              found <= 1'b1;
            scan <= scan + 1'b1;
          end
        end
        // earliest deadline search
        S_QUERY: begin
          if (scan == NS) begin
            if (!best_ok) next_delay <= '1;
            else if (now_t >= best_dl) next_delay <= '0;
            else next_delay <= 48'(best_dl - now_t);
            any_active <= |act;
            state <= S_IDLE;
          end else begin
            if (act[sj] && sj_before) begin
              best <= sj; best_dl <= dl_mem[sj]; best_ok <= 1'b1;
            end
            scan <= scan + 1'b1;
          end
        end
        // mark due slots
        S_DUE: begin
          if (scan == NS) begin
            scan <= '0;
            best_ok <= 1'b0;
            state <= S_PICK;
          end else begin
            due[sj] <= act[sj] && (roll || dl_mem[sj] <= now_t);
            scan <= scan + 1'b1;
          end
        end
        // pick earliest due slot
        S_PICK: begin
          if (scan == NS) begin
            if (best_ok) state <= S_UPD;
            else begin
              // nothing due at all
              ok <= 1'b1; slot_out <= '0; expired <= 1'b0; last <= 1'b1;
              any_active <= |act;
              state <= S_IDLE;
            end
          end else begin
            if (due[sj] && sj_before) begin
              best <= sj; best_dl <= dl_mem[sj]; best_ok <= 1'b1;
            end
            scan <= scan + 1'b1;
          end
        end
        // emit and retire best slot
        S_UPD: begin
          due[best] <= 1'b0;
          if (rep[best]) dl_mem[best] <= now_t + per_mem[best];
          else act[best] <= 1'b0;
          ok <= 1'b1;
          expired <= 1'b1;
          slot_out <= SLOT_W'(best);
          last <= !(|(due & ~(NUM_SLOTS'(1) << best)));
          any_active <= |act_after;
          scan <= '0;
          best_ok <= 1'b0;
          state <= (|(due & ~(NUM_SLOTS'(1) << best))) ? S_DONE : S_IDLE;
        end
        S_DONE: state <= S_PICK;
        default: state <= S_IDLE;
      endcase
    end
  end

  // active set once all currently due one-shots are freed
  always_comb begin
    act_after = act;
    for (int j = 0; j < NUM_SLOTS; j++)
      if (due[j] && !rep[j]) act_after[j] = 1'b0;
  end
endmodule

>>> hdl/ordered_timer_manager.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_timer_manager: table of one-shot and recurring timers
// Channel   | handshake        | payload
// command   | start / busy     | cmd now_ms slot_in period_ms repeat_req restart_now
// result    | done (1 cycle)   | ok slot_out expired next_delay front_notice any_active last
// config    | cfg_we           | cfg_data (rollover window)
// Simple commands are answered directly; add and a changing reset make one scan
// of the slot table, as does query; collect makes one scan to mark due slots,
// then one scan per expired result to pick it, one slot per cycle through the
// shared deadline compare. A two-entry queue takes items while the back end
// works. Reset is synchronous; results cannot stall.
// ---------------------------------------------------------------------------
module ordered_timer_manager #(
  parameter int NUM_SLOTS = otm_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = otm_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [otm_pkg::CMD_W-1:0] cmd,
  input  logic [47:0] now_ms,
  input  logic [otm_pkg::SLOT_W-1:0] slot_in,
  input  logic [47:0] period_ms,
  input  logic repeat_req,
  input  logic restart_now,
  input  logic cfg_we,
  input  logic [otm_pkg::WIN_W-1:0] cfg_data,
  output logic done,
  output logic ok,
  output logic [otm_pkg::SLOT_W-1:0] slot_out,
  output logic expired,
  output logic [47:0] next_delay,
  output logic front_notice,
  output logic any_active,
  output logic last
);
  import otm_pkg::*;

  otm_item_t in_item, q_item;
  logic      q_valid, q_pop;

  assign in_item = '{cmd: cmd, now: now_ms, slot: slot_in, period: period_ms,
                     rep: repeat_req, fnow: restart_now};

  otm_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  otm_back #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .strobe(done), .ok(ok), .slot_out(slot_out), .expired(expired),
    .next_delay(next_delay), .front_notice(front_notice),
    .any_active(any_active), .last(last)
  );
endmodule

>>> dv/tb_ordered_timer_manager.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ordered_timer_manager: self-checking bench for the timer table
// Drives directed and random command items, predicts every result item
// from a behavioral copy of the timer table and compares each one in order.
// ---------------------------------------------------------------------------
module tb_ordered_timer_manager;
  import otm_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [47:0] ONES48 = '1;
  localparam int IDLE_LIMIT = 20000;
  // codes with no command behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [47:0]       now;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       period;
    logic              rep;
    logic              fnow;
    logic              cfg;      // config write instead of a command
    logic              drain;    // wait for all results first
  } stim_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              exp_flag;
    logic [47:0]       delay;
    logic              notice;
    logic              any;
    logic              lst;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = '0;
  logic [47:0] now_ms = '0;
  logic [SLOT_W-1:0] slot_in = '0;
  logic [47:0] period_ms = '0;
  logic repeat_req = 1'b0;
  logic restart_now = 1'b0;
  logic cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_data = '0;
  logic done, ok, expired, front_notice, any_active, last;
  logic [SLOT_W-1:0] slot_out;
  logic [47:0] next_delay;

  ordered_timer_manager dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .now_ms(now_ms), .slot_in(slot_in), .period_ms(period_ms),
    .repeat_req(repeat_req), .restart_now(restart_now), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(done), .ok(ok), .slot_out(slot_out),
    .expired(expired), .next_delay(next_delay), .front_notice(front_notice),
    .any_active(any_active), .last(last)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [47:0] per_tbl [NSLOT];
  logic [47:0] due_tbl [NSLOT];
  logic        act_tbl [NSLOT];
  logic        rep_tbl [NSLOT];
  logic        per_written [NSLOT];
  logic [47:0] last_now;
  logic        notice_held;
  logic [47:0] window;

  stim_t pending_items[$];
  timer_result_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int expiries_seen = 0;
  int idle_cycles = 0;

  function automatic bit earlier(int a, int b);
    if (due_tbl[a] != due_tbl[b]) return due_tbl[a] < due_tbl[b];
    return a < b;
  endfunction

  function automatic bit front_check(int s);
    for (int j = 0; j < NSLOT; j++)
      if (j != s && act_tbl[j] && earlier(j, s)) return 1'b0;
    if (notice_held) return 1'b0;
    notice_held = 1'b1;
    return 1'b1;
  endfunction

  function automatic timer_result_t mk(bit k, int s, bit e, logic [47:0] d, bit n);
    timer_result_t r;
    r = '0;
    r.ok = k; r.slot = s[SLOT_W-1:0]; r.exp_flag = e; r.delay = d; r.notice = n;
    return r;
  endfunction

  // compute expected result items of one command and queue them
  task automatic predict_timers(stim_t it);
    timer_result_t res[$];
    int f, best;
    bit any, roll, hit;
    bit due_now [NSLOT];
    logic [47:0] st;
    res = {};
    case (it.op)
      CMD_ADD: begin
        f = -1;
        for (int j = NSLOT - 1; j >= 0; j--) if (!act_tbl[j]) f = j;
        if (f < 0) res = {res, mk(0, 0, 0, 0, 0)};
        else begin
          per_tbl[f] = it.period; per_written[f] = 1'b1;
          due_tbl[f] = it.now + it.period;
          rep_tbl[f] = it.rep; act_tbl[f] = 1'b1;
          res = {res, mk(1, f, 0, 0, front_check(f))};
        end
      end
      CMD_CANCEL: begin
        hit = act_tbl[it.slot];
        if (hit) act_tbl[it.slot] = 1'b0;
        res = {res, mk(hit, it.slot, 0, 0, 0)};
      end
      CMD_REFRESH: begin
        hit = act_tbl[it.slot];
        if (hit) due_tbl[it.slot] = it.now + per_tbl[it.slot];
        res = {res, mk(hit, it.slot, 0, 0, 0)};
      end
      CMD_RESET: begin
        if (it.period == per_tbl[it.slot] && !it.fnow)
          res = {res, mk(1, it.slot, 0, 0, 0)};
        else if (!act_tbl[it.slot]) res = {res, mk(0, it.slot, 0, 0, 0)};
        else begin
          st = it.fnow ? it.now : due_tbl[it.slot] - per_tbl[it.slot];
          per_tbl[it.slot] = it.period;
          due_tbl[it.slot] = st + it.period;
          res = {res, mk(1, it.slot, 0, 0, front_check(it.slot))};
        end
      end
      CMD_COLLECT: begin
        any = 1'b0;
        for (int j = 0; j < NSLOT; j++) any |= act_tbl[j];
        if (any) begin
          roll = it.now < last_now && (last_now - it.now) > window;
          last_now = it.now;
          for (int j = 0; j < NSLOT; j++)
            due_now[j] = act_tbl[j] && (roll || due_tbl[j] <= it.now);
          forever begin
            best = -1;
            for (int j = 0; j < NSLOT; j++)
              if (due_now[j] && (best < 0 || earlier(j, best))) best = j;
            if (best < 0) break;
            due_now[best] = 1'b0;
            res = {res, mk(1, best, 1, 0, 0)};
          end
          // state update only after the order is fixed
          foreach (res[k]) begin
            if (rep_tbl[res[k].slot]) due_tbl[res[k].slot] = it.now + per_tbl[res[k].slot];
            else act_tbl[res[k].slot] = 1'b0;
          end
        end
        if (res.size() == 0) res = {res, mk(1, 0, 0, 0, 0)};
      end
      CMD_QUERY: begin
        notice_held = 1'b0;
        best = -1;
        for (int j = 0; j < NSLOT; j++)
          if (act_tbl[j] && (best < 0 || earlier(j, best))) best = j;
        if (best < 0) res = {res, mk(1, 0, 0, ONES48, 0)};
        else res = {res, mk(1, 0, 0,
          (it.now >= due_tbl[best]) ? 48'd0 : due_tbl[best] - it.now, 0)};
      end
      default: res = {res, mk(0, 0, 0, 0, 0)};
    endcase
    any = 1'b0;
    for (int j = 0; j < NSLOT; j++) any |= act_tbl[j];
    foreach (res[k]) begin
      res[k].any = any;
      res[k].lst = (k == res.size() - 1);
      expected_results = {expected_results, res[k]};
    end
  endtask

  // --- stimulus building ---
  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic push_cmd(logic [CMD_W-1:0] op, logic [47:0] t, int s,
                          logic [47:0] p, bit r, bit fn);
    stim_t it;
    it = '0;
    it.op = op; it.now = t; it.slot = s[SLOT_W-1:0]; it.period = p;
    it.rep = r; it.fnow = fn;
    pending_items = {pending_items, it};
  endtask

  task automatic push_cfg(logic [47:0] v);
    stim_t it;
    it = '0;
    it.cfg = 1'b1; it.now = v; it.drain = 1'b1;
    pending_items = {pending_items, it};
  endtask

  task automatic push_drain();
    stim_t it;
    it = '0;
    it.drain = 1'b1; it.op = CMD_QUERY; it.now = 48'd0;
    pending_items = {pending_items, it};
  endtask

  // --- driver ---
  int gap_pct = 10;
  int settle = 0;
  bit took;

  always @(negedge clk) begin : drive
    stim_t it;
    if (rst) begin
      start <= 1'b0; cfg_we <= 1'b0;
    end else if (start && !took) begin
      // item still waiting to be taken
      cfg_we <= 1'b0;
    end else if (pending_items.size() == 0) begin
      start <= 1'b0; cfg_we <= 1'b0;
    end else if (pending_items[0].drain &&
                 (expected_results.size() != 0 || settle < 40)) begin
      start <= 1'b0; cfg_we <= 1'b0;
      settle <= (expected_results.size() != 0) ? 0 : settle + 1;
    end else if (($urandom_range(99) < gap_pct)) begin
      start <= 1'b0; cfg_we <= 1'b0;
    end else begin
      it = pending_items.pop_front();
      settle <= 0;
      // never reset a slot whose period was never written
      if (!it.cfg && it.op == CMD_RESET && !per_written[it.slot]) it.op = CMD_CANCEL;
      if (it.cfg) begin
        cfg_we <= 1'b1; cfg_data <= it.now;
        start <= 1'b0;
      end else begin
        cfg_we <= 1'b0;
        start <= 1'b1;
        cmd <= it.op; now_ms <= it.now; slot_in <= it.slot;
        period_ms <= it.period; repeat_req <= it.rep; restart_now <= it.fnow;
      end
    end
  end

  // acceptance sample at the rising edge
  always @(posedge clk) begin : accept
    stim_t it;
    took = 1'b0;
    if (!rst) begin
      if (cfg_we) window = cfg_data;
      if (start && !busy) begin
        took = 1'b1;
        it = '0;
        it.op = cmd; it.now = now_ms; it.slot = slot_in; it.period = period_ms;
        it.rep = repeat_req; it.fnow = restart_now;
        predict_timers(it);
        items_sent++;
      end
    end
  end

  // --- monitor ---
  always @(posedge clk) begin : monitor
    timer_result_t got, want;
    if (!rst && done) begin
      got = '0;
      got.ok = ok; got.slot = slot_out; got.exp_flag = expired; got.delay = next_delay;
      got.notice = front_notice; got.any = any_active; got.lst = last;
      results_seen++;
      if (expired) expiries_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result item differs: expected %p got %p", want, got);
        end
      end
    end
  end

  // --- watchdog ---
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ordered_timer_manager: mismatch");
      $finish;
    end
  end

  initial begin
    logic [47:0] t;
    int kind;
    for (int j = 0; j < NSLOT; j++) begin
      per_tbl[j] = '0; due_tbl[j] = '0; act_tbl[j] = 1'b0; rep_tbl[j] = 1'b0;
      per_written[j] = 1'b0;
    end
    last_now = '0; notice_held = 1'b0; window = WINDOW_RESET;

    // directed part
    push_cmd(CMD_QUERY, 48'd0, 0, 0, 0, 0);              // empty table
    push_cmd(CMD_COLLECT, 48'd100, 0, 0, 0, 0);          // empty collect
    push_cmd(CMD_CANCEL, 48'd0, 15, 0, 0, 0);            // inactive slot
    push_cmd(CMD_ADD, 48'd1000, 0, 48'd50, 1, 0);        // front notice
    push_cmd(CMD_ADD, 48'd1000, 0, 48'd20, 0, 0);        // front, notice held
    push_cmd(CMD_QUERY, 48'd1005, 0, 0, 0, 0);
    push_cmd(CMD_ADD, 48'd1000, 0, ONES48, 1, 0);        // wrapping deadline
    push_cmd(CMD_REFRESH, 48'd1010, 0, 0, 0, 0);
    push_cmd(CMD_RESET, 48'd1010, 1, 48'd5, 0, 1);       // from now
    push_cmd(CMD_RESET, 48'd1010, 0, 48'd30, 0, 0);      // from old start
    push_cmd(CMD_RESET, 48'd1010, 0, 48'd30, 0, 0);      // unchanged
    push_cmd(CMD_COLLECT, 48'd1100, 0, 0, 0, 0);
    push_cmd(CMD_UNUSED_A, ONES48, 15, ONES48, 1, 1);    // unknown codes
    push_cmd(CMD_UNUSED_B, 48'd0, 0, 0, 0, 0);
    for (int j = 0; j < 15; j++) push_cmd(CMD_ADD, 48'd2000, 0, 48'(j * 3), j[0], 0);
    push_cmd(CMD_ADD, 48'd2000, 0, 48'd1, 0, 0);         // table full
    push_cmd(CMD_COLLECT, 48'd10, 0, 0, 0, 0);           // backward step inside window
    push_drain();
    push_cfg('0);
    push_cmd(CMD_COLLECT, 48'd9, 0, 0, 0, 0);            // tiny window rollover
    push_drain();
    push_cfg(ONES48);

    // random part: time mostly advances; occasional jumps to a random time
    t = 48'd5000;
    for (int n = 0; n < 85; n++) begin
      if (n == 40) begin push_drain(); push_cfg(48'd1000); end
      if (n == 80) begin push_drain(); push_cfg(WINDOW_RESET); end
      if (n == 60) push_drain();
      if ($urandom_range(19) == 0) t = rnd48();
      else t = t + 48'($urandom_range(60));
      kind = $urandom_range(99);
      if (kind < 30)
        push_cmd(CMD_ADD, t, 0,
                 ($urandom_range(9) == 0) ? rnd48() : 48'($urandom_range(80)),
                 1'($urandom_range(1)), 0);
      else if (kind < 40) push_cmd(CMD_CANCEL, t, $urandom_range(15), 0, 0, 0);
      else if (kind < 48) push_cmd(CMD_REFRESH, t, $urandom_range(15), 0, 0, 0);
      else if (kind < 60)
        push_cmd(CMD_RESET, t, $urandom_range(15),
                 ($urandom_range(7) == 0) ? rnd48() : 48'($urandom_range(80)),
                 0, 1'($urandom_range(1)));
      else if (kind < 82) push_cmd(CMD_COLLECT, t, 0, 0, 0, 0);
      else if (kind < 97) push_cmd(CMD_QUERY, t, 0, 0, 0, 0);
      else push_cmd($urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B, rnd48(),
                    $urandom_range(15), rnd48(), 1, 1);
    end
    push_drain();

    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // no random gaps through the middle stretch
    wait (items_sent >= 50);
    gap_pct = 0;
    wait (items_sent >= 75);
    gap_pct = 10;

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("ran %0d command items, %0d result items, %0d expiries",
             items_sent, results_seen, expiries_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("ordered_timer_manager: match");
    else
      $display("ordered_timer_manager: mismatch");
    $finish;
  end
endmodule
